>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They expand to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Types, constants and helpers of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

    localparam int DIM_W      = 9;   // configured sizes
    localparam int EDIM_W     = 10;  // effective destination size, up to 512
    localparam int COORD_W    = 8;
    localparam int SPROD_W    = COORD_W + DIM_W;   // row * src size
    localparam int IDX_W      = 27;  // srow * src_w + scol, full range
    localparam int WIDX_W     = 16;
    localparam int PIXEL_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_POW2_MODE  = 3'd4
    } t_cfg_reg;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [WIDX_W-1:0]   write_index;
        logic [PIXEL_W-1:0]  write_pixel;
        logic [COORD_W-1:0]  out_row;
        logic [COORD_W-1:0]  out_col;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic [WIDX_W-1:0]   source_index;
        logic                coord_error;
    } t_out_item;

    typedef struct packed {
        logic load;        // latch the accepted item and effective sizes
        logic div_start;   // start row and column divisions
        logic mod_start;   // start store address reduction
        logic mod_sel_wr;  // address comes from the write index
        logic mem_we;
        logic mem_re;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_read;
        logic coord_err;
        logic div_done;
        logic mod_done;
        logic out_free;
    } t_ctrl_sts;

    // Smallest power of two >= n; zero gives one.
    function automatic logic [EDIM_W-1:0] f_pow2_ceil(input logic [DIM_W-1:0] n);
        logic [EDIM_W-1:0] p;
        p = EDIM_W'(1) << (EDIM_W - 1);
        for (int i = EDIM_W - 1; i >= 0; i--) begin
            if ((EDIM_W'(1) << i) >= EDIM_W'(n)) begin
                p = EDIM_W'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> rtl/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle. o_done pulses once the last
// quotient bit is in; the quotient then holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_div #(
    parameter int NW = 17,
    parameter int DW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [NW-1:0] o_quo,
    output logic               o_done
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      w_shift;
    logic             w_ge;
    logic [DW:0]      w_diff;

    assign w_shift = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            // remainder stays below the divisor, so DW bits hold it
            r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/nnis_ctrl.sv
// ----------------------------------------------------------------------------
// nnis_ctrl
// Sequencer of the scaler: takes one item, steps the datapath through the
// division, address reduction, store access and result transfer it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire nnis_pkg::t_ctrl_sts i_sts,
    output nnis_pkg::t_ctrl_cmd      o_cmd
);
    import nnis_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_INDEX  = 8'b0000_1000,
        S_MOD    = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_read) begin
                    o_cmd.mod_start  = 1'b1;
                    o_cmd.mod_sel_wr = 1'b1;
                    n_state          = S_MOD;
                end else if (i_sts.coord_err) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: begin
                o_cmd.mod_start = 1'b1;
                n_state         = S_MOD;
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = i_sts.is_read ? S_READ : S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.mem_we = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                o_cmd.mem_re = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> rtl/nnis_dpath.sv
// ----------------------------------------------------------------------------
// nnis_dpath
// Datapath of the scaler: size registers, item latch, coordinate dividers,
// index multiply-add, store address reduction, frame store and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_dpath #(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [nnis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [nnis_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire nnis_pkg::t_in_item                  i_in_data,
    input  wire nnis_pkg::t_ctrl_cmd                 i_cmd,
    output nnis_pkg::t_ctrl_sts                      o_sts,
    output nnis_pkg::t_out_item                      o_out_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready
);
    import nnis_pkg::*;

    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int AW         = $clog2(DEPTH);
    localparam bit DEPTH_POW2 = (DEPTH & (DEPTH - 1)) == 0;

    // size registers
    logic [DIM_W-1:0] r_src_w;
    logic [DIM_W-1:0] r_src_h;
    logic [DIM_W-1:0] r_dst_w;
    logic [DIM_W-1:0] r_dst_h;
    logic             r_pow2;

    // item latch
    logic                  r_req;
    logic [WIDX_W-1:0]     r_widx;
    logic [PIXEL_BITS-1:0] r_wpix;
    logic [COORD_W-1:0]    r_row;
    logic [COORD_W-1:0]    r_col;
    logic [EDIM_W-1:0]     r_dw;
    logic [EDIM_W-1:0]     r_dh;

    logic                  w_coord_err;
    logic [SPROD_W-1:0]    w_row_prod;
    logic [SPROD_W-1:0]    w_col_prod;
    logic [SPROD_W-1:0]    w_srow;
    logic [SPROD_W-1:0]    w_scol;
    logic                  w_div_done;
    logic                  w_div_col_done;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      w_mod_num;
    logic [AW-1:0]         w_addr;
    logic                  w_mod_done;

    logic [PIXEL_BITS-1:0] mem [0:DEPTH-1];
    logic [PIXEL_BITS-1:0] r_rd_data;

    t_out_item r_out;
    logic      r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DIM_W'(256);
            r_src_h <= DIM_W'(256);
            r_dst_w <= DIM_W'(256);
            r_dst_h <= DIM_W'(256);
            r_pow2  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                CFG_POW2_MODE:  r_pow2  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in_data.req_type;
            r_widx <= i_in_data.write_index;
            r_wpix <= i_in_data.write_pixel[PIXEL_BITS-1:0];
            r_row  <= i_in_data.out_row;
            r_col  <= i_in_data.out_col;
            r_dw   <= r_pow2 ? f_pow2_ceil(r_src_w) : EDIM_W'(r_dst_w);
            r_dh   <= r_pow2 ? f_pow2_ceil(r_src_h) : EDIM_W'(r_dst_h);
        end
    end

    // a zero effective destination size makes every coordinate fail, so no division by zero starts
    assign w_coord_err = (EDIM_W'(r_row) >= r_dh) || (EDIM_W'(r_col) >= r_dw);

    assign w_row_prod = SPROD_W'(r_row) * SPROD_W'(r_src_h);
    assign w_col_prod = SPROD_W'(r_col) * SPROD_W'(r_src_w);

    nnis_div #(
        .NW (SPROD_W),
        .DW (EDIM_W)
    ) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_row_prod),
        .i_den   (r_dh),
        .o_quo   (w_srow),
        .o_done  (w_div_done)
    );

    // same length as the row division, finishes in the same cycle
    nnis_div #(
        .NW (SPROD_W),
        .DW (EDIM_W)
    ) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_col_prod),
        .i_den   (r_dw),
        .o_quo   (w_scol),
        .o_done  (w_div_col_done)
    );

    assign w_idx     = IDX_W'(w_srow) * IDX_W'(r_src_w) + IDX_W'(w_scol);
    assign w_mod_num = i_cmd.mod_sel_wr ? IDX_W'(r_widx) : w_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_idx <= w_idx;
        end
    end

    // store address = index modulo depth
    generate
        if (DEPTH_POW2) begin : g_mask
            logic [AW-1:0] r_addr;
            logic          r_mod_done;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mod_done <= 1'b0;
                end else begin
                    r_mod_done <= i_cmd.mod_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.mod_start) begin
                    r_addr <= w_mod_num[AW-1:0];
                end
            end

            assign w_addr     = r_addr;
            assign w_mod_done = r_mod_done;
        end else begin : g_mod
            // quotient estimate by reciprocal multiply is exact or one low,
            // so one conditional subtract finishes the remainder
            localparam int SH_W   = IDX_W + AW;
            localparam int RCP_W  = IDX_W + 1;
            localparam int PROD_W = IDX_W + RCP_W;
            localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << SH_W) / 64'(DEPTH));

            logic [IDX_W-1:0]  r_num;
            logic [IDX_W-1:0]  r_qest;
            logic [AW:0]       r_rem;
            logic [AW-1:0]     r_addr;
            logic [2:0]        r_vld;
            logic              r_mod_done;
            logic [PROD_W-1:0] w_prod;
            logic [IDX_W-1:0]  w_back;

            assign w_prod = PROD_W'(r_num) * PROD_W'(RCP);
            assign w_back = r_qest * IDX_W'(DEPTH);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld      <= '0;
                    r_mod_done <= 1'b0;
                end else begin
                    r_vld      <= {r_vld[1:0], i_cmd.mod_start};
                    r_mod_done <= r_vld[2];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.mod_start) begin
                    r_num <= w_mod_num;
                end
                r_qest <= IDX_W'(w_prod >> SH_W);
                r_rem  <= (AW+1)'(r_num - w_back);
                r_addr <= (r_rem >= (AW+1)'(DEPTH)) ? AW'(r_rem - (AW+1)'(DEPTH))
                                                    : r_rem[AW-1:0];
            end

            assign w_addr     = r_addr;
            assign w_mod_done = r_mod_done;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[w_addr] <= r_wpix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_re) begin
            r_rd_data <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.pixel        <= w_coord_err ? '0 : PIXEL_W'(r_rd_data);
            r_out.source_index <= w_coord_err ? '0 : r_idx[WIDX_W-1:0];
            r_out.coord_error  <= w_coord_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.is_read   = (r_req == REQ_READ);
    assign o_sts.coord_err = w_coord_err;
    assign o_sts.div_done  = w_div_done && w_div_col_done;
    assign o_sts.mod_done  = w_mod_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Frame store with nearest-neighbor resampling on read.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, i_in_data) carries write items that
// store a pixel at a raster index and read items that ask for an output
// row/column. Only reads produce a transfer on the output channel
// (o_out_valid/i_out_ready, o_out_data).
// One item at a time. A write passes decode, address reduction and the store
// write; a read adds two 17-step dividers side by side, then the index
// multiply-add, store read and result register; a read with a coordinate error
// goes straight from decode to the result register. Other store depths add a
// reciprocal address reduction to writes and to in-range reads.
// The result sits in an output register; the next item is taken once it is
// loaded, so a stalled receiver only blocks once a second result is ready.
// Reset (i_rst_n low, synchronous) returns sizes to 256x256, clears pow2 mode
// and empties the output register; store contents are undefined until written.
// The user must write size registers through i_cfg_* only while idle; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_image_scaler #(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [nnis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [nnis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire nnis_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output nnis_pkg::t_out_item                  o_out_data
);
    import nnis_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    nnis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nnis_dpath #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

`include "assert_macros.svh"

    // one item at a time
    `ASSERT_NEXT(a_single_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // a result never overwrites one still waiting
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !o_out_valid || i_out_ready)
    // dividers start only on in-range reads
    `ASSERT_IMPL(a_div_in_range, i_clk, i_rst_n, w_cmd.div_start, w_sts.is_read && !w_sts.coord_err)
    // store writes come only from write items
    `ASSERT_IMPL(a_write_item, i_clk, i_rst_n, w_cmd.mem_we, !w_sts.is_read)

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor image scaler. A short scripted
// run covers size extremes, zero and oversized sizes, power-of-two rounding
// and out-of-range reads. Random write/read traffic follows under several size
// settings and both-side stalls. Every sample is checked against a fixed value
// from the script or a local scaler model that tracks the frame store and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nnis_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 40;    // longest item without a result is far shorter
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASES_PER_MODE = 5;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int MAX_REPORTS     = 10;
    localparam int STORE_DEPTH     = 65536;

    localparam t_out_item OUT_OF_RANGE = '{pixel: '0, source_index: '0, coord_error: 1'b1};
    localparam t_out_item NO_CHECK     = '0;

    typedef struct packed {
        bit                  is_cfg;
        logic [DIM_W-1:0]    sw;
        logic [DIM_W-1:0]    sh;
        logic [DIM_W-1:0]    dw;
        logic [DIM_W-1:0]    dh;
        logic                p2;
        t_in_item            item;
        bit                  typed;
        t_out_item           want;
    } t_script_row;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    t_cfg_reg              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    t_in_item              in_data;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_data;

    // scaler model state
    logic [DIM_W-1:0] cur_src_w  = 9'd256;
    logic [DIM_W-1:0] cur_src_h  = 9'd256;
    int unsigned      out_w_eff  = 256;
    int unsigned      out_h_eff  = 256;
    logic [PIXEL_W-1:0] frame_copy [STORE_DEPTH];
    bit                 written_map [STORE_DEPTH];

    t_out_item   pending_samples[$];
    t_out_item   head_sample;
    t_script_row script[$];
    int          send_idle_pct = 8;
    int          recv_idle_pct = 84;
    int          fail_count    = 0;
    int          quiet_cycles  = 0;

    nearest_neighbor_image_scaler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic int unsigned pow2_ceil(input int unsigned n);
        int unsigned p;
        p = 1;
        while (p < n) p = p << 1;
        return p;
    endfunction

    function automatic t_out_item sample_pixel(input t_in_item it);
        int unsigned srow;
        int unsigned scol;
        int unsigned idx;
        t_out_item   res;
        if (32'(it.out_row) >= out_h_eff || 32'(it.out_col) >= out_w_eff) begin
            return OUT_OF_RANGE;
        end
        srow = (32'(it.out_row) * 32'(cur_src_h)) / out_h_eff;
        scol = (32'(it.out_col) * 32'(cur_src_w)) / out_w_eff;
        idx  = srow * 32'(cur_src_w) + scol;
        res.pixel        = frame_copy[idx[15:0]];
        res.source_index = idx[15:0];
        res.coord_error  = 1'b0;
        return res;
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        case ($urandom_range(0, 15))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'd511;
            4:       return 9'($urandom_range(257, 510));
            default: return 9'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned lim);
        if (lim == 0 || $urandom_range(0, 4) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, (lim > 256 ? 256 : lim) - 1));
    endfunction

    task automatic script_cfg(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                              input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                              input logic p2);
        t_script_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.sw = sw;
        r.sh = sh;
        r.dw = dw;
        r.dh = dh;
        r.p2 = p2;
        script.push_back(r);
    endtask

    task automatic script_item(input logic req, input logic [WIDX_W-1:0] widx,
                               input logic [PIXEL_W-1:0] pix, input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col, input bit typed,
                               input t_out_item want);
        t_script_row r;
        r = '0;
        r.item  = '{req_type: req, write_index: widx, write_pixel: pix,
                    out_row: row, out_col: col};
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endtask

    // holds valid until the transfer, then updates the model
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (it.req_type == REQ_WRITE) begin
            frame_copy[it.write_index]  = it.write_pixel;
            written_map[it.write_index] = 1'b1;
        end else begin
            pending_samples.push_back(typed ? want : sample_pixel(it));
        end
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                              input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                              input logic p2);
        drain_block();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SRC_WIDTH;
        cfg_data  <= sw;
        @(posedge clk);
        cfg_index <= CFG_SRC_HEIGHT;
        cfg_data  <= sh;
        @(posedge clk);
        cfg_index <= CFG_DST_WIDTH;
        cfg_data  <= dw;
        @(posedge clk);
        cfg_index <= CFG_DST_HEIGHT;
        cfg_data  <= dh;
        @(posedge clk);
        cfg_index <= CFG_POW2_MODE;
        cfg_data  <= CFG_DATA_W'(p2);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_src_w = sw;
        cur_src_h = sh;
        out_w_eff = p2 ? pow2_ceil(32'(sw)) : 32'(dw);
        out_h_eff = p2 ? pow2_ceil(32'(sh)) : 32'(dh);
    endtask

    // result checker, receiver stalls and watchdog
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_samples.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result pixel %h index %h err %b", $time,
                             out_data.pixel, out_data.source_index, out_data.coord_error);
                end
            end else begin
                head_sample = pending_samples.pop_front();
                if (head_sample.pixel !== out_data.pixel
                        || head_sample.source_index !== out_data.source_index
                        || head_sample.coord_error !== out_data.coord_error) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: sample mismatch: expected pixel %h index %h err %b,",
                                 $time, head_sample.pixel, head_sample.source_index,
                                 head_sample.coord_error,
                                 " got pixel %h index %h err %b", out_data.pixel,
                                 out_data.source_index, out_data.coord_error);
                    end
                end
            end
        end
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        t_in_item    item;
        t_in_item    fill;
        t_out_item   guess;
        int          issued;
        int unsigned rows_max;
        int unsigned cols_max;

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_SRC_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;

        // reset sizes: 256x256 to 256x256
        script_item(REQ_WRITE, 16'h0000, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0, NO_CHECK);
        script_item(REQ_WRITE, 16'hFFFF, 32'h8000_0001, 8'h00, 8'h00, 1'b0, NO_CHECK);
        script_item(REQ_READ, 16'hFFFF, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b1,
                    '{pixel: 32'hFFFF_FFFF, source_index: 16'h0000, coord_error: 1'b0});
        script_item(REQ_READ, 16'h0000, 32'h0000_0000, 8'd255, 8'd255, 1'b1,
                    '{pixel: 32'h8000_0001, source_index: 16'hFFFF, coord_error: 1'b0});
        // zero destination sizes
        script_cfg(9'd256, 9'd256, 9'd0, 9'd256, 1'b0);
        script_item(REQ_READ, 16'h0000, 32'h0, 8'd0, 8'd0, 1'b1, OUT_OF_RANGE);
        script_cfg(9'd256, 9'd256, 9'd256, 9'd0, 1'b0);
        script_item(REQ_READ, 16'h0000, 32'h0, 8'd0, 8'd0, 1'b1, OUT_OF_RANGE);
        // zero source in power-of-two mode rounds to 1x1
        script_cfg(9'd0, 9'd0, 9'd256, 9'd256, 1'b1);
        script_item(REQ_READ, 16'h0000, 32'h0, 8'd0, 8'd0, 1'b1,
                    '{pixel: 32'hFFFF_FFFF, source_index: 16'h0000, coord_error: 1'b0});
        script_item(REQ_READ, 16'h0000, 32'h0, 8'd0, 8'd1, 1'b1, OUT_OF_RANGE);
        script_item(REQ_READ, 16'h0000, 32'h0, 8'd1, 8'd0, 1'b1, OUT_OF_RANGE);
        // oversized source, index wraps past the store
        script_cfg(9'd511, 9'd511, 9'd256, 9'd256, 1'b1);
        script_item(REQ_WRITE, 16'd64512, 32'h1234_5678, 8'd3, 8'd9, 1'b0, NO_CHECK);
        script_item(REQ_READ, 16'h0, 32'h0, 8'd255, 8'd255, 1'b0, NO_CHECK);
        // 3x5 source rounds to 4x8
        script_cfg(9'd3, 9'd5, 9'd256, 9'd256, 1'b1);
        script_item(REQ_WRITE, 16'd14, 32'hDEAD_BEEF, 8'h00, 8'h00, 1'b0, NO_CHECK);
        script_item(REQ_READ, 16'h0, 32'h0, 8'd7, 8'd3, 1'b0, NO_CHECK);
        script_item(REQ_READ, 16'h0, 32'h0, 8'd8, 8'd0, 1'b1, OUT_OF_RANGE);
        script_item(REQ_READ, 16'h0, 32'h0, 8'd0, 8'd4, 1'b1, OUT_OF_RANGE);
        // zero source without rounding samples the origin
        script_cfg(9'd0, 9'd0, 9'd256, 9'd256, 1'b0);
        script_item(REQ_READ, 16'h0, 32'h0, 8'd200, 8'd100, 1'b0, NO_CHECK);
        script_cfg(9'd256, 9'd256, 9'd1, 9'd1, 1'b0);
        script_item(REQ_READ, 16'h0, 32'h0, 8'd0, 8'd0, 1'b1,
                    '{pixel: 32'hFFFF_FFFF, source_index: 16'h0000, coord_error: 1'b0});
        script_item(REQ_READ, 16'h0, 32'h0, 8'd0, 8'd1, 1'b1, OUT_OF_RANGE);
        // oversized destination without rounding
        script_cfg(9'd256, 9'd256, 9'd511, 9'd511, 1'b0);
        script_item(REQ_WRITE, 16'd32639, 32'h0F0F_0F0F, 8'h55, 8'hAA, 1'b0, NO_CHECK);
        script_item(REQ_READ, 16'h0, 32'h0, 8'd255, 8'd255, 1'b0, NO_CHECK);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                set_config(script[i].sw, script[i].sh, script[i].dw, script[i].dh,
                           script[i].p2);
            end else begin
                send_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 84 : 0;
            recv_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 8 : 0;
            for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
                set_config(pick_size(), pick_size(), pick_size(), pick_size(),
                           1'($urandom_range(0, 1)));
                rows_max = (cur_src_h == 0) ? 1 : 32'(cur_src_h);
                cols_max = (cur_src_w == 0) ? 1 : 32'(cur_src_w);
                issued = 0;
                while (issued < ITEMS_PER_PHASE) begin
                    item.write_pixel = $urandom();
                    item.out_row     = 8'($urandom_range(0, 255));
                    item.out_col     = 8'($urandom_range(0, 255));
                    item.write_index = 16'($urandom_range(0, 65535));
                    if ($urandom_range(0, 99) < 30) begin
                        item.req_type = REQ_WRITE;
                        // mostly inside the source image
                        if ($urandom_range(0, 3) != 0) begin
                            item.write_index = 16'($urandom_range(0, rows_max - 1)
                                                   * 32'(cur_src_w)
                                                   + $urandom_range(0, cols_max - 1));
                        end
                    end else begin
                        item.req_type = REQ_READ;
                        item.out_row  = pick_coord(out_h_eff);
                        item.out_col  = pick_coord(out_w_eff);
                        guess = sample_pixel(item);
                        // never sample a store entry that was not written
                        if (!guess.coord_error && !written_map[guess.source_index]) begin
                            fill             = item;
                            fill.req_type    = REQ_WRITE;
                            fill.write_index = guess.source_index;
                            fill.write_pixel = $urandom();
                            send_item(fill, 1'b0, NO_CHECK);
                            issued++;
                        end
                    end
                    send_item(item, 1'b0, NO_CHECK);
                    issued++;
                end
            end
        end

        drain_block();
        if (fail_count == 0 && pending_samples.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
